// ===== rtl/dlsq_pkg.sv =====
// package for the delta list sleep queue
// types, widths and constants shared by the core, controller and converter
package dlsq_pkg;

  localparam int unsigned ENTRY_SLOTS_DEF = 32;
  localparam int unsigned PID_W           = 5;
  localparam int unsigned TPS_W           = 14;
  localparam int unsigned MS_W            = 32;
  localparam int unsigned TICK_W          = 32;
  localparam int unsigned PROD_W          = TPS_W + MS_W;
  localparam int unsigned MS_PER_SEC      = 1000;

  localparam logic [TPS_W-1:0] TPS_RESET = 14'd100;

  localparam logic OP_SLEEP = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  localparam int unsigned APB_AW  = 3;
  localparam logic        REG_TPS = 1'b0;

  typedef struct packed {
    logic              done;
    logic [TICK_W-1:0] ticks;
  } conv_stat_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TO_CHK,
    ST_TO_ADD,
    ST_CONV_WAIT,
    ST_INS_WALK,
    ST_INS_FIN,
    ST_INS_LINK,
    ST_TK_HEAD,
    ST_TK_WAKE,
    ST_TK_PEEK
  } state_e;

endpackage

// ===== rtl/dlsq_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
module dlsq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/dlsq_conv.sv =====
// milliseconds to ticks converter: registered product, then division by 1000 as a
// reciprocal multiply over four partial products; depends on dlsq_pkg
module dlsq_conv
  import dlsq_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [TPS_W-1:0] tps_i,
  input  logic [MS_W-1:0]  ms_i,
  output conv_stat_t       stat_o
);

  localparam int unsigned PLO_W = 21;
  localparam int unsigned MLO_W = 22;
  localparam int unsigned MHI_W = 21;
  localparam int unsigned MUL_W = PLO_W + MLO_W;
  localparam int unsigned SHIFT = 52;
  localparam int unsigned ACC_W = SHIFT + TICK_W;
  // ceil(2**52 / 1000), exact for every product below 1000 * 2**32
  localparam logic [MLO_W+MHI_W-1:0] RECIP   = 43'd4503599627371;
  localparam logic [PROD_W-1:0]      SAT_LIM = PROD_W'(MS_PER_SEC) << TICK_W;

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [1:0]        step_q, step_d;
  logic [PROD_W-1:0] prod_q, prod_d;
  logic [ACC_W-1:0]  acc_q, acc_d;
  logic [PLO_W-1:0]  mul_a;
  logic [MLO_W-1:0]  mul_b;
  logic [MUL_W-1:0]  mul_p;
  logic [ACC_W-1:0]  part;

  always_comb begin
    mul_a = step_q[1] ? prod_q[2*PLO_W-1:PLO_W] : prod_q[PLO_W-1:0];
    mul_b = step_q[0] ? MLO_W'(RECIP[MLO_W+MHI_W-1:MLO_W]) : RECIP[MLO_W-1:0];
    mul_p = MUL_W'(mul_a) * MUL_W'(mul_b);
    unique case (step_q)
      2'd0: part = ACC_W'(mul_p);
      2'd1: part = ACC_W'(mul_p) << MLO_W;
      2'd2: part = ACC_W'(mul_p) << PLO_W;
      2'd3: part = ACC_W'(mul_p) << (PLO_W + MLO_W);
    endcase
    busy_d = busy_q;
    done_d = done_q;
    step_d = step_q;
    prod_d = prod_q;
    acc_d  = acc_q;
    if (start_i) begin
      busy_d = 1'b1;
      done_d = 1'b0;
      step_d = '0;
      prod_d = PROD_W'(tps_i) * PROD_W'(ms_i);
      acc_d  = '0;
    end else if (busy_q) begin
      acc_d  = acc_q + part;
      step_d = step_q + 2'd1;
      if (step_q == 2'd3) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    acc_q  <= acc_d;
  end

  assign stat_o.done  = done_q;
  assign stat_o.ticks = (prod_q >= SAT_LIM) ? '1 : acc_q[ACC_W-1:SHIFT];

endmodule

// ===== rtl/dlsq_ctrl.sv =====
// sequencer for the delta list: removal walk, insertion walk and tick wake-up
// depends on dlsq_pkg; drives the link and delta rams and the converter
module dlsq_ctrl
  import dlsq_pkg::*;
#(
  parameter int unsigned ENTRY_SLOTS = ENTRY_SLOTS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           opcode_i,
  input  logic [PID_W-1:0]               process_id_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [PID_W-1:0]               woken_id_o,
  output logic                           last_woken_o,
  output logic                           conv_start_o,
  input  conv_stat_t                     conv_stat_i,
  output logic                           mem_re_o,
  output logic [$clog2(ENTRY_SLOTS)-1:0] mem_raddr_o,
  input  logic [$clog2(ENTRY_SLOTS)-1:0] link_rdata_i,
  input  logic [TICK_W-1:0]              delta_rdata_i,
  output logic                           link_we_o,
  output logic [$clog2(ENTRY_SLOTS)-1:0] link_waddr_o,
  output logic [$clog2(ENTRY_SLOTS)-1:0] link_wdata_o,
  output logic                           delta_we_o,
  output logic [$clog2(ENTRY_SLOTS)-1:0] delta_waddr_o,
  output logic [TICK_W-1:0]              delta_wdata_o
);

  localparam int unsigned IW = $clog2(ENTRY_SLOTS);

  state_e            state_q, state_d;
  logic [IW-1:0]     head_q, head_d;
  logic [IW-1:0]     id_q, cur_q, prev_q, w_q, nx_q;
  logic              at_head_q;
  logic [TICK_W-1:0] acc_q, dn_q, did_q;
  logic              out_valid_q;
  logic [PID_W-1:0]  woken_q;
  logic              last_q;

  logic              accept, id_ok, out_free, match, ge, emit, emit_last;
  logic [TICK_W:0]   sum;

  assign accept   = in_valid_i && in_ready_o;
  assign id_ok    = (process_id_i != '0) && (32'(process_id_i) < 32'(ENTRY_SLOTS));
  assign out_free = !out_valid_q || out_ready_i;
  assign match    = cur_q == id_q;
  assign sum      = {1'b0, acc_q} + {1'b0, delta_rdata_i};
  assign ge       = sum >= {1'b0, conv_stat_i.ticks};

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (opcode_i == OP_TICK) begin
            if (head_q != '0) state_d = ST_TK_HEAD;
          end else if (id_ok) begin
            state_d = (head_q == '0) ? ST_CONV_WAIT : ST_TO_CHK;
          end
        end
      end
      ST_TO_CHK: begin
        if (match) begin
          state_d = (link_rdata_i != '0) ? ST_TO_ADD : ST_CONV_WAIT;
        end else if (link_rdata_i == '0) begin
          state_d = ST_CONV_WAIT;
        end
      end
      ST_TO_ADD:    state_d = ST_CONV_WAIT;
      ST_CONV_WAIT: begin
        if (conv_stat_i.done) state_d = (head_q == '0) ? ST_INS_FIN : ST_INS_WALK;
      end
      ST_INS_WALK: begin
        if (ge || link_rdata_i == '0) state_d = ST_INS_FIN;
      end
      ST_INS_FIN:  state_d = ST_INS_LINK;
      ST_INS_LINK: state_d = ST_IDLE;
      ST_TK_HEAD: begin
        state_d = (delta_rdata_i <= TICK_W'(1)) ? ST_TK_WAKE : ST_IDLE;
      end
      ST_TK_WAKE: begin
        if (nx_q != '0) state_d = ST_TK_PEEK;
        else if (out_free) state_d = ST_IDLE;
      end
      ST_TK_PEEK: begin
        if (out_free) state_d = (delta_rdata_i == '0) ? ST_TK_WAKE : ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // memory, converter and output controls
  always_comb begin
    mem_re_o      = 1'b0;
    mem_raddr_o   = head_q;
    link_we_o     = 1'b0;
    link_waddr_o  = prev_q;
    link_wdata_o  = link_rdata_i;
    delta_we_o    = 1'b0;
    delta_waddr_o = cur_q;
    delta_wdata_o = delta_rdata_i;
    conv_start_o  = 1'b0;
    emit          = 1'b0;
    emit_last     = 1'b1;
    head_d        = head_q;
    unique case (state_q)
      ST_IDLE: begin
        mem_re_o     = accept && (head_q != '0) && ((opcode_i == OP_TICK) || id_ok);
        conv_start_o = accept && (opcode_i == OP_SLEEP) && id_ok;
      end
      ST_TO_CHK: begin
        mem_raddr_o = link_rdata_i;
        mem_re_o    = link_rdata_i != '0;
        if (match) begin
          if (at_head_q) head_d = link_rdata_i;
          else link_we_o = 1'b1;
        end
      end
      ST_TO_ADD: begin
        delta_we_o    = 1'b1;
        delta_wdata_o = delta_rdata_i + acc_q;
      end
      ST_CONV_WAIT: begin
        mem_re_o = conv_stat_i.done && (head_q != '0);
      end
      ST_INS_WALK: begin
        mem_raddr_o = link_rdata_i;
        mem_re_o    = !ge && (link_rdata_i != '0);
      end
      ST_INS_FIN: begin
        link_we_o     = 1'b1;
        link_waddr_o  = id_q;
        link_wdata_o  = cur_q;
        delta_we_o    = 1'b1;
        delta_waddr_o = id_q;
        delta_wdata_o = conv_stat_i.ticks - acc_q;
      end
      ST_INS_LINK: begin
        link_wdata_o  = id_q;
        link_we_o     = !at_head_q;
        if (at_head_q) head_d = id_q;
        delta_we_o    = cur_q != '0;
        delta_wdata_o = dn_q - did_q;
      end
      ST_TK_HEAD: begin
        delta_we_o    = delta_rdata_i > TICK_W'(1);
        delta_wdata_o = delta_rdata_i - TICK_W'(1);
      end
      ST_TK_WAKE: begin
        head_d      = nx_q;
        mem_raddr_o = nx_q;
        mem_re_o    = nx_q != '0;
        emit        = (nx_q == '0) && out_free;
      end
      ST_TK_PEEK: begin
        emit          = out_free;
        emit_last     = delta_rdata_i != '0;
        delta_waddr_o = nx_q;
        delta_we_o    = out_free && (delta_rdata_i != '0);
        delta_wdata_o = delta_rdata_i - TICK_W'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      if (emit) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      woken_q <= PID_W'(w_q);
      last_q  <= emit_last;
    end
    unique case (state_q)
      ST_IDLE: begin
        id_q      <= IW'(process_id_i);
        cur_q     <= head_q;
        at_head_q <= 1'b1;
      end
      ST_TO_CHK: begin
        cur_q <= link_rdata_i;
        if (match) begin
          acc_q <= delta_rdata_i;
        end else begin
          prev_q    <= cur_q;
          at_head_q <= 1'b0;
        end
      end
      ST_CONV_WAIT: begin
        acc_q     <= '0;
        at_head_q <= 1'b1;
        cur_q     <= head_q;
      end
      ST_INS_WALK: begin
        dn_q <= delta_rdata_i;
        if (!ge) begin
          acc_q     <= sum[TICK_W-1:0];
          prev_q    <= cur_q;
          at_head_q <= 1'b0;
          cur_q     <= link_rdata_i;
        end
      end
      ST_INS_FIN: did_q <= conv_stat_i.ticks - acc_q;
      ST_TK_HEAD: begin
        w_q  <= cur_q;
        nx_q <= link_rdata_i;
      end
      ST_TK_PEEK: begin
        if (out_free && delta_rdata_i == '0) begin
          w_q  <= nx_q;
          nx_q <= link_rdata_i;
        end
      end
      ST_TO_ADD, ST_INS_LINK, ST_TK_WAKE: ;
      default: ;
    endcase
  end

  assign in_ready_o   = state_q == ST_IDLE;
  assign out_valid_o  = out_valid_q;
  assign woken_id_o   = woken_q;
  assign last_woken_o = last_q;

  a_link_wr_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    link_we_o |-> link_waddr_o != '0)
    else $error("link write to reserved slot");

  a_delta_wr_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    delta_we_o |-> delta_waddr_o != '0)
    else $error("delta write to reserved slot");

  a_wake_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_TK_WAKE || state_q == ST_TK_PEEK))
    else $error("wake result outside tick walk");

  a_conv_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    conv_start_o |=> !conv_stat_i.done)
    else $error("converter done not cleared on start");

  a_walk_pred: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_INS_LINK && !at_head_q |-> prev_q != '0)
    else $error("insertion without predecessor");

endmodule

// ===== rtl/delta_list_sleep_queue_core.sv =====
// Sleep timer queue kept as a delta list; top level with register port.
// Requests enter on in_valid_i/in_ready_o: opcode 0 puts process_id_i to sleep
// for milliseconds_i, opcode 1 reports one timer tick. Wake results leave on
// out_valid_o/out_ready_i as woken_id_o with last_woken_o on the final one.
// One request is worked at a time; in_ready_o is high only when idle.
// A sleep request runs the ms to tick conversion (registered
// product, then four partial products of a reciprocal multiply), overlapped
// with the removal walk, then the insertion walk and the link states
// ST_INS_FIN and ST_INS_LINK; with 32 slots, up to 31 entries can be queued.
// A tick on an empty queue needs no ram read; else the head entry is read,
// then each woken entry in turn. The removal and insertion walks read the
// link and delta rams one entry per cycle.
// A sleep request gives no result; a tick with nothing due gives none.
// ticks_per_second sits at byte address 0 of the apb port, reset value 100.
// Reset empties the queue at once; ram contents need no clearing.
// A result waits in an output register while the receiver stalls; the walk
// holds on a further wake result until that register frees.
module delta_list_sleep_queue_core
  import dlsq_pkg::*;
#(
  parameter int unsigned ENTRY_SLOTS = ENTRY_SLOTS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              opcode_i,
  input  logic [PID_W-1:0]  process_id_i,
  input  logic [MS_W-1:0]   milliseconds_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [PID_W-1:0]  woken_id_o,
  output logic              last_woken_o
);

  localparam int unsigned IW = $clog2(ENTRY_SLOTS);

  logic [TPS_W-1:0]  tps_q;
  conv_stat_t        conv_stat;
  logic              conv_start;
  logic              mem_re;
  logic [IW-1:0]     mem_raddr;
  logic [IW-1:0]     link_rdata, link_waddr, link_wdata, delta_waddr;
  logic [TICK_W-1:0] delta_rdata, delta_wdata;
  logic              link_we, delta_we;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tps_q <= TPS_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_TPS) begin
      tps_q <= pwdata[TPS_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_TPS) ? 32'(tps_q) : '0;

  dlsq_conv u_conv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(conv_start),
    .tps_i  (tps_q),
    .ms_i   (milliseconds_i),
    .stat_o (conv_stat)
  );

  dlsq_ram #(.WIDTH(IW), .DEPTH(ENTRY_SLOTS)) u_link_ram (
    .clk_i  (clk_i),
    .we_i   (link_we),
    .waddr_i(link_waddr),
    .wdata_i(link_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(link_rdata)
  );

  dlsq_ram #(.WIDTH(TICK_W), .DEPTH(ENTRY_SLOTS)) u_delta_ram (
    .clk_i  (clk_i),
    .we_i   (delta_we),
    .waddr_i(delta_waddr),
    .wdata_i(delta_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(delta_rdata)
  );

  dlsq_ctrl #(.ENTRY_SLOTS(ENTRY_SLOTS)) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .opcode_i     (opcode_i),
    .process_id_i (process_id_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .woken_id_o   (woken_id_o),
    .last_woken_o (last_woken_o),
    .conv_start_o (conv_start),
    .conv_stat_i  (conv_stat),
    .mem_re_o     (mem_re),
    .mem_raddr_o  (mem_raddr),
    .link_rdata_i (link_rdata),
    .delta_rdata_i(delta_rdata),
    .link_we_o    (link_we),
    .link_waddr_o (link_waddr),
    .link_wdata_o (link_wdata),
    .delta_we_o   (delta_we),
    .delta_waddr_o(delta_waddr),
    .delta_wdata_o(delta_wdata)
  );

endmodule
